// File: sv/ttps_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the transposition table probe/store unit
// no dependencies; imported by every other file of the block

package ttps_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned OCC_W         = 11;

  // field widths
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned MOVE_W  = 24;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_STORE = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2,
    BOUND_RSVD  = 2'd3
  } bound_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_CLEAR,
    ST_CLEAR_DONE
  } back_state_e;

  // classified command
  typedef struct packed {
    kind_e                      kind;
    logic [IDX_W-1:0]           idx;
    logic [KEY_W-1:0]           key;
    logic                       key_nz;
    logic [DEPTH_W-1:0]         depth;
    logic signed [SCORE_W-1:0]  alpha;
    logic signed [SCORE_W-1:0]  beta;
    bound_e                     bound;
    logic signed [SCORE_W-1:0]  score;
    logic [MOVE_W-1:0]          move;
  } cmd_t;

  // one table entry
  typedef struct packed {
    logic [KEY_W-1:0]           key;
    logic [DEPTH_W-1:0]         depth;
    bound_e                     bound;
    logic signed [SCORE_W-1:0]  score;
    logic [MOVE_W-1:0]          move;
  } entry_t;

  // one result
  typedef struct packed {
    logic                       usable;
    logic                       cutoff;
    logic signed [SCORE_W-1:0]  hit_score;
    logic [MOVE_W-1:0]          hit_move;
    logic [OCC_W-1:0]           occupied_count;
  } res_t;

  // queue status toward front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // back status toward front
  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

// File: sv/ttps_if.sv
`timescale 1ns / 1ps
// channel interfaces of the transposition table probe/store unit
// depends on ttps_pkg for field widths

interface ttps_in_if;
  import ttps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [KEY_W-1:0]          key;
  logic [DEPTH_W-1:0]        depth;
  logic signed [SCORE_W-1:0] alpha;
  logic signed [SCORE_W-1:0] beta;
  logic [1:0]                bound;
  logic signed [SCORE_W-1:0] score;
  logic [MOVE_W-1:0]         move;

  modport source (
    output valid, kind, key, depth, alpha, beta, bound, score, move,
    input  ready
  );
  modport sink (
    input  valid, kind, key, depth, alpha, beta, bound, score, move,
    output ready
  );
endinterface

interface ttps_out_if;
  import ttps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      usable;
  logic                      cutoff;
  logic signed [SCORE_W-1:0] hit_score;
  logic [MOVE_W-1:0]         hit_move;
  logic [OCC_W-1:0]          occupied_count;

  modport source (
    output valid, usable, cutoff, hit_score, hit_move, occupied_count,
    input  ready
  );
  modport sink (
    input  valid, usable, cutoff, hit_score, hit_move, occupied_count,
    output ready
  );
endinterface

// File: sv/ttps_front.sv
`timescale 1ns / 1ps
// front end: accepts input transactions, classifies them and pushes them to the queue
// depends on ttps_pkg and ttps_in_if

module ttps_front import ttps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttps_in_if.sink     in_i,
  input  q_stat_t     q_stat_i,
  input  back_stat_t  back_stat_i,
  output logic        push_o,
  output cmd_t        push_cmd_o
);

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  logic take;
  logic drain;

  // hold one classified command until the queue has room
  assign drain      = vld_q && !q_stat_i.full;
  assign in_i.ready = (!vld_q || !q_stat_i.full) && !back_stat_i.init_busy;
  assign take       = in_i.valid && in_i.ready;

  // classify: entry index, key occupancy and decoded codes
  always_comb begin
    vld_d = vld_q;
    cmd_d = cmd_q;
    if (drain) begin
      vld_d = 1'b0;
    end
    if (take) begin
      vld_d        = 1'b1;
      cmd_d.kind   = kind_e'(in_i.kind);
      cmd_d.idx    = in_i.key[IDX_W-1:0];
      cmd_d.key    = in_i.key;
      cmd_d.key_nz = |in_i.key;
      cmd_d.depth  = in_i.depth;
      cmd_d.alpha  = in_i.alpha;
      cmd_d.beta   = in_i.beta;
      cmd_d.bound  = bound_e'(in_i.bound);
      cmd_d.score  = in_i.score;
      cmd_d.move   = in_i.move;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign push_o     = drain;
  assign push_cmd_o = cmd_q;

endmodule

// File: sv/ttps_queue.sv
`timescale 1ns / 1ps
// short command queue decoupling front end and back end
// depends on ttps_pkg

module ttps_queue import ttps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    push_cmd_i,
  input  logic    pop_i,
  output cmd_t    head_o,
  output q_stat_t stat_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_o       = slot_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: sv/ttps_back.sv
`timescale 1ns / 1ps
// back end: table memory, lookup/update sequencer, clear sweep and result register
// depends on ttps_pkg and ttps_out_if

module ttps_back import ttps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        head_i,
  input  q_stat_t     q_stat_i,
  output logic        pop_o,
  output back_stat_t  stat_o,
  ttps_out_if.source  out_o
);

  entry_t mem [TABLE_ENTRIES];

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  entry_t            rd_q;
  logic [IDX_W-1:0]  sweep_q, sweep_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic              out_vld_q, out_vld_d;
  res_t              res_q, res_d;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic              slot_free;
  logic              sweep_last;
  logic              hit;
  logic              cut;
  logic              was_occ;

  assign slot_free  = !out_vld_q || out_o.ready;
  assign sweep_last = (sweep_q == {IDX_W{1'b1}});

  // probe evaluation on the registered entry
  assign hit     = (rd_q.key == cmd_q.key) && (rd_q.depth >= cmd_q.depth);
  assign was_occ = |rd_q.key;

  always_comb begin
    unique case (rd_q.bound)
      BOUND_EXACT: cut = 1'b1;
      BOUND_UPPER: cut = (rd_q.score <= cmd_q.alpha);
      BOUND_LOWER: cut = (rd_q.score >= cmd_q.beta);
      default:     cut = 1'b0;
    endcase
  end

  // sequencer: next state, memory write and result
  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    occ_d     = occ_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cmd_q.idx;
    mem_wdata = '{key: cmd_q.key, depth: cmd_q.depth, bound: cmd_q.bound,
                  score: cmd_q.score, move: cmd_q.move};
    out_vld_d = out_vld_q && !out_o.ready;
    res_d     = res_q;

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_last) begin
          occ_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          if (head_i.kind == KIND_CLEAR) begin
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          res_d     = '0;
          if (cmd_q.kind == KIND_PROBE && hit) begin
            res_d.usable    = 1'b1;
            res_d.cutoff    = cut;
            res_d.hit_score = rd_q.score;
            res_d.hit_move  = rd_q.move;
          end
          if (cmd_q.kind == KIND_STORE) begin
            mem_we = 1'b1;
            if (was_occ && !cmd_q.key_nz) begin
              occ_d = occ_q - 1'b1;
            end else if (!was_occ && cmd_q.key_nz) begin
              occ_d = occ_q + 1'b1;
            end
          end
          res_d.occupied_count = occ_d;
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_last) begin
          occ_d   = '0;
          state_d = ST_CLEAR_DONE;
        end
      end
      ST_CLEAR_DONE: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          res_d     = '0;
          res_d.occupied_count = occ_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      sweep_q   <= '0;
      occ_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      occ_q     <= occ_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pop_o) begin
      cmd_q <= head_i;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop_o) begin
      rd_q <= mem[head_i.idx];
    end
  end

  assign stat_o.init_busy = (state_q == ST_INIT);

  assign out_o.valid          = out_vld_q;
  assign out_o.usable         = res_q.usable;
  assign out_o.cutoff         = res_q.cutoff;
  assign out_o.hit_score      = res_q.hit_score;
  assign out_o.hit_move       = res_q.hit_move;
  assign out_o.occupied_count = res_q.occupied_count;

endmodule

// File: sv/transposition_table_probe_store_unit.sv
`timescale 1ns / 1ps
// a probe or store passes the front register, a queue slot and the table read register
// before its result is registered; the back end reads and writes back one at a time
// a clear walks the table one entry a cycle, then its result is registered
// reset: asynchronous, active low; a clearing pass of all TABLE_ENTRIES (1024) entries
// follows, during which the input stays not ready
// depends on ttps_pkg, ttps_if, ttps_front, ttps_queue and ttps_back

module transposition_table_probe_store_unit import ttps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttps_in_if.sink     in_i,
  ttps_out_if.source  out_o
);

  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       head;
  q_stat_t    q_stat;
  back_stat_t back_stat;

  // accept and classify
  ttps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .back_stat_i (back_stat),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  // decoupling queue
  ttps_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // table access and results
  ttps_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .stat_o   (back_stat),
    .out_o    (out_o)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_no_take_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.init_busy |-> !in_i.ready)
    else $error("input taken during clearing pass");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.occupied_count <= OCC_W'(TABLE_ENTRIES)))
    else $error("occupied count beyond table size");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the transposition table probe/store unit
// depends on ttps_pkg, ttps_if and the transposition_table_probe_store_unit rtl

module testbench;
  import ttps_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned TAIL_ITEMS   = 150;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned POOL_SIZE    = 48;

  // one request as the sender holds it
  typedef struct {
    kind_e                     kind;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    bound_e                    bound;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
    bit                        hold_for_drain;
  } tt_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ttps_in_if  in_if ();
  ttps_out_if out_if ();

  transposition_table_probe_store_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow copy of the table
  entry_t      shadow_table [TABLE_ENTRIES];
  int unsigned shadow_occupied;

  tt_req_t pending_requests [$];
  tt_req_t recent_stores [$];
  res_t    expected_results [$];
  tt_req_t active_req;

  int unsigned total_requests;
  int unsigned accepted_count;
  int unsigned result_count;
  int unsigned fault_count;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned take_left;
  bit          take_stall;
  res_t        seen_result;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void wipe_shadow_table();
    foreach (shadow_table[i]) shadow_table[i] = '0;
    shadow_occupied = 0;
  endfunction

  // expected result of one transaction, updating the shadow table
  function automatic res_t predict_table_result(tt_req_t rq);
    res_t             r;
    logic [IDX_W-1:0] slot;
    entry_t           e;
    r    = '0;
    slot = rq.key[IDX_W-1:0];
    e    = shadow_table[slot];
    case (rq.kind)
      KIND_PROBE: begin
        if (e.key == rq.key && e.depth >= rq.depth) begin
          r.usable    = 1'b1;
          r.hit_score = e.score;
          r.hit_move  = e.move;
          case (e.bound)
            BOUND_EXACT: r.cutoff = 1'b1;
            BOUND_UPPER: r.cutoff = ($signed(e.score) <= $signed(rq.alpha));
            BOUND_LOWER: r.cutoff = ($signed(e.score) >= $signed(rq.beta));
            default:     r.cutoff = 1'b0;
          endcase
        end
      end
      KIND_STORE: begin
        if (e.key != '0 && rq.key == '0) begin
          shadow_occupied--;
        end else if (e.key == '0 && rq.key != '0) begin
          shadow_occupied++;
        end
        shadow_table[slot].key   = rq.key;
        shadow_table[slot].depth = rq.depth;
        shadow_table[slot].bound = rq.bound;
        shadow_table[slot].score = rq.score;
        shadow_table[slot].move  = rq.move;
      end
      KIND_CLEAR: wipe_shadow_table();
      default: ;
    endcase
    r.occupied_count = OCC_W'(shadow_occupied);
    return r;
  endfunction

  function automatic tt_req_t make_req(kind_e k, logic [KEY_W-1:0] key,
                                       logic [DEPTH_W-1:0] depth,
                                       logic signed [SCORE_W-1:0] lo,
                                       logic signed [SCORE_W-1:0] hi, bound_e b,
                                       logic signed [SCORE_W-1:0] sc,
                                       logic [MOVE_W-1:0] mv);
    tt_req_t rq;
    rq.kind           = k;
    rq.key            = key;
    rq.depth          = depth;
    rq.alpha          = lo;
    rq.beta           = hi;
    rq.bound          = b;
    rq.score          = sc;
    rq.move           = mv;
    rq.hold_for_drain = 1'b0;
    return rq;
  endfunction

  // random key: fully random, zero, colliding on a few slots, or reused
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       k = '0;
      1, 2, 3: if (recent_stores.size() != 0)
                 k = recent_stores[$urandom_range(0, recent_stores.size() - 1)].key;
      4, 5, 6: k[IDX_W-1:0] = IDX_W'($urandom_range(0, 7));
      default: ;
    endcase
    return k;
  endfunction

  task automatic report_fault(string what, res_t want, res_t seen);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%s at result %0d: expected u=%0b c=%0b score=%0d move=%06h occ=%0d",
               what, result_count, want.usable, want.cutoff, want.hit_score,
               want.hit_move, want.occupied_count);
      $display("  got u=%0b c=%0b score=%0d move=%06h occ=%0d",
               seen.usable, seen.cutoff, seen.hit_score, seen.hit_move,
               seen.occupied_count);
    end
  endtask

  // driver: presents queued requests, records expectations on each transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(predict_table_result(active_req));
        accepted_count++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          in_if.valid <= 1'b0;
          send_gap--;
        end else if (pending_requests.size() != 0 &&
                     (!pending_requests[0].hold_for_drain ||
                      expected_results.size() == 0)) begin
          active_req = pending_requests.pop_front();
          in_if.valid <= 1'b1;
          in_if.kind  <= active_req.kind;
          in_if.key   <= active_req.key;
          in_if.depth <= active_req.depth;
          in_if.alpha <= active_req.alpha;
          in_if.beta  <= active_req.beta;
          in_if.bound <= active_req.bound;
          in_if.score <= active_req.score;
          in_if.move  <= active_req.move;
          if (pending_requests.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 14);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results in order and paces the output ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      take_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen_result.usable         = out_if.usable;
        seen_result.cutoff         = out_if.cutoff;
        seen_result.hit_score      = out_if.hit_score;
        seen_result.hit_move       = out_if.hit_move;
        seen_result.occupied_count = out_if.occupied_count;
        result_count++;
        if (expected_results.size() == 0) begin
          report_fault("unexpected result", '0, seen_result);
        end else if (seen_result.usable !== expected_results[0].usable ||
                     seen_result.cutoff !== expected_results[0].cutoff ||
                     seen_result.hit_score !== expected_results[0].hit_score ||
                     seen_result.hit_move !== expected_results[0].hit_move ||
                     seen_result.occupied_count !== expected_results[0].occupied_count) begin
          report_fault("mismatch", expected_results.pop_front(), seen_result);
        end else begin
          void'(expected_results.pop_front());
        end
      end
      // ready bursts, always ready near the end
      if (pending_requests.size() < TAIL_ITEMS) begin
        out_if.ready <= 1'b1;
      end else if (take_left == 0) begin
        take_stall = ($urandom_range(0, 2) == 0);
        out_if.ready <= !take_stall;
        take_left = take_stall ? $urandom_range(1, 14) : $urandom_range(1, 40);
      end else begin
        take_left--;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    tt_req_t     rq;
    tt_req_t     p;
    int unsigned work_items;
    int unsigned pick;
    int          d;

    in_if.valid  = 1'b0;
    in_if.kind   = KIND_PROBE;
    in_if.key    = '0;
    in_if.depth  = '0;
    in_if.alpha  = '0;
    in_if.beta   = '0;
    in_if.bound  = BOUND_EXACT;
    in_if.score  = '0;
    in_if.move   = '0;
    out_if.ready = 1'b0;
    wipe_shadow_table();

    // directed: cleared entries, extremes, every bound rule, zero key
    pending_requests.push_back(make_req(KIND_PROBE, '0, 8'd0, 16'sd0, 16'sd0,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_PROBE, '0, 8'd1, 16'sd0, 16'sd0,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_STORE, '1, 8'd255, 16'sd0, 16'sd0,
                                        BOUND_EXACT, 16'sd32767, 24'hFFFFFF));
    pending_requests.push_back(make_req(KIND_PROBE, '1, 8'd255, -16'sd32768, 16'sd32767,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_STORE, 64'd2, 8'd10, 16'sd0, 16'sd0,
                                        BOUND_UPPER, 16'sd100, 24'h123456));
    pending_requests.push_back(make_req(KIND_PROBE, 64'd2, 8'd10, 16'sd99, 16'sd0,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_PROBE, 64'd2, 8'd11, 16'sd100, 16'sd0,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_PROBE, 64'd2, 8'd0, 16'sd100, 16'sd0,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_STORE, 64'd3, 8'd0, 16'sd0, 16'sd0,
                                        BOUND_LOWER, -16'sd32768, 24'd7));
    pending_requests.push_back(make_req(KIND_PROBE, 64'd3, 8'd0, 16'sd0, -16'sd32768,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_PROBE, 64'd3, 8'd0, 16'sd0, -16'sd32767,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_STORE, 64'd4, 8'd2, 16'sd0, 16'sd0,
                                        BOUND_RSVD, 16'sd5, 24'hABCDEF));
    pending_requests.push_back(make_req(KIND_PROBE, 64'd4, 8'd2, 16'sd32767, -16'sd32768,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_STORE, 64'd1028, 8'd2, 16'sd0, 16'sd0,
                                        BOUND_EXACT, 16'sd9, 24'd9));
    pending_requests.push_back(make_req(KIND_PROBE, 64'd4, 8'd0, 16'sd0, 16'sd0,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_STORE, 64'd1024, 8'd1, 16'sd0, 16'sd0,
                                        BOUND_EXACT, 16'sd1, 24'd1));
    pending_requests.push_back(make_req(KIND_STORE, '0, 8'd5, 16'sd0, 16'sd0,
                                        BOUND_EXACT, 16'sd7, 24'd123));
    pending_requests.push_back(make_req(KIND_PROBE, '0, 8'd5, 16'sd0, 16'sd0,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_STORE, 64'd5, 8'd3, 16'sd0, 16'sd0,
                                        BOUND_LOWER, 16'sd32767, 24'd5));
    pending_requests.push_back(make_req(KIND_PROBE, 64'd5, 8'd3, -16'sd32768, 16'sd32767,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_NOP, '1, 8'd255, -16'sd1, -16'sd1,
                                        BOUND_RSVD, -16'sd1, 24'hFFFFFF));
    rq = make_req(KIND_CLEAR, 64'd77, 8'd0, 16'sd0, 16'sd0, BOUND_EXACT, 16'sd0, 24'd0);
    rq.hold_for_drain = 1'b1;
    pending_requests.push_back(rq);
    pending_requests.push_back(make_req(KIND_PROBE, '1, 8'd0, 16'sd0, 16'sd0,
                                        BOUND_EXACT, 16'sd0, 24'd0));
    pending_requests.push_back(make_req(KIND_PROBE, '0, 8'd0, 16'sd0, 16'sd0,
                                        BOUND_EXACT, 16'sd0, 24'd0));

    // random: stores and probes that revisit recent keys, rare clears and no-ops
    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      rq.kind           = KIND_PROBE;
      rq.key            = {$urandom, $urandom};
      rq.depth          = DEPTH_W'($urandom);
      rq.alpha          = SCORE_W'($urandom);
      rq.beta           = SCORE_W'($urandom);
      rq.bound          = bound_e'($urandom_range(0, 3));
      rq.score          = SCORE_W'($urandom);
      rq.move           = MOVE_W'($urandom);
      rq.hold_for_drain = ($urandom_range(0, 199) == 0);
      pick = $urandom_range(0, 999);
      if (pick < 5) begin
        rq.kind = KIND_CLEAR;
        recent_stores.delete();
      end else if (pick < 30) begin
        rq.kind = KIND_NOP;
      end else if (pick < 500) begin
        rq.kind  = KIND_STORE;
        rq.key   = random_key();
        rq.bound = ($urandom_range(0, 9) == 0) ? BOUND_RSVD :
                                                bound_e'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
          0:       rq.score = 16'sh7FFF;
          1:       rq.score = 16'sh8000;
          default: ;
        endcase
        recent_stores.push_back(rq);
        if (recent_stores.size() > POOL_SIZE) void'(recent_stores.pop_front());
      end else if (recent_stores.size() != 0 && $urandom_range(0, 9) < 7) begin
        p      = recent_stores[$urandom_range(0, recent_stores.size() - 1)];
        rq.key = p.key;
        case ($urandom_range(0, 3))
          0: rq.depth = p.depth;
          1: rq.depth = p.depth - DEPTH_W'($urandom_range(0, 2));
          2: rq.depth = p.depth + 8'd1;
          default: rq.depth = '0;
        endcase
        if ($urandom_range(0, 1) == 0) begin
          d        = int'($urandom_range(0, 4)) - 2;
          rq.alpha = SCORE_W'(p.score + d);
          d        = int'($urandom_range(0, 4)) - 2;
          rq.beta  = SCORE_W'(p.score + d);
        end
      end else begin
        rq.key = random_key();
        if ($urandom_range(0, 3) == 0) rq.depth = '0;
      end
      if (rq.kind != KIND_NOP) work_items++;
      pending_requests.push_back(rq);
    end
    total_requests = pending_requests.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count < total_requests || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
